>>> design/bsp_point_locate_top_assert.svh
// ----------------------------------------------------------------------------
// bsp_point_locate_top_assert.svh
// Assertion macros for the partition tree point locator.
// ----------------------------------------------------------------------------
`ifndef BSP_POINT_LOCATE_TOP_ASSERT_SVH
`define BSP_POINT_LOCATE_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BPL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsp_point_locate: same-cycle check failed");

// next-cycle implication, disabled in reset
`define BPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsp_point_locate: next-cycle check failed");

`endif

>>> design/bpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared types and constants of the partition tree point locator.
// ----------------------------------------------------------------------------
package bpl_pkg;

  localparam logic        CMD_WRITE  = 1'b0;
  localparam logic        CMD_LOCATE = 1'b1;

  // register select taken from paddr[2]
  localparam logic        REG_ROOT   = 1'b0;
  localparam logic        REG_COUNT  = 1'b1;

  localparam int          LEAF_BIT   = 15;
  localparam logic [31:0] SIGN32     = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [15:0] back;
    logic [15:0] front;
  } node_t;

  // multiplier control from the sequencer
  typedef struct packed {
    logic mul_en;    // capture a product
    logic mul_sel;   // 0: left product, 1: right product
    logic keep_left; // move previous product into the left register
  } mul_ctl_t;

  // side test status back to the sequencer
  typedef struct packed {
    logic resolved;  // special case or sign shortcut decided the side
    logic side_fast; // side from the special case
    logic side_mul;  // side from the product compare
  } side_sts_t;

endpackage

>>> design/bpl_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_node_mem
// Node table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bpl_node_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  bpl_pkg::node_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output bpl_pkg::node_t rd_data
);

  bpl_pkg::node_t mem [DEPTH];
  bpl_pkg::node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/bpl_side_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_side_unit
// Side test of a point against a node's line, with one shared multiplier.
// ----------------------------------------------------------------------------
module bpl_side_unit (
  input  logic                clk,
  input  bpl_pkg::node_t      node,
  input  logic [31:0]         point_x,
  input  logic [31:0]         point_y,
  input  bpl_pkg::mul_ctl_t   ctl,
  output bpl_pkg::side_sts_t  sts
);

  logic [31:0]        wdx;
  logic [31:0]        wdy;
  logic signed [15:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [47:0] prod_r;
  logic signed [31:0] left_r;
  logic               sign_mix;

  assign wdx = point_x - node.start_x;
  assign wdy = point_y - node.start_y;
  assign sign_mix = |((node.dir_y ^ node.dir_x ^ wdx ^ wdy) & bpl_pkg::SIGN32);

  always_comb begin
    // right < left selects the front side
    sts.side_mul  = !($signed(prod_r[47:16]) < left_r);
    sts.resolved  = 1'b1;
    sts.side_fast = 1'b0;
    if (node.dir_x == 32'd0) begin
      // vertical line
      if ($signed(point_x) <= $signed(node.start_x)) begin
        sts.side_fast = $signed(node.dir_y) > 0;
      end else begin
        sts.side_fast = $signed(node.dir_y) < 0;
      end
    end else if (node.dir_y == 32'd0) begin
      // horizontal line
      if ($signed(point_y) <= $signed(node.start_y)) begin
        sts.side_fast = $signed(node.dir_x) < 0;
      end else begin
        sts.side_fast = $signed(node.dir_x) > 0;
      end
    end else if (sign_mix) begin
      sts.side_fast = |((node.dir_y ^ wdx) & bpl_pkg::SIGN32);
    end else begin
      sts.resolved = 1'b0;
    end
  end

  // integer part of the direction times the full-width difference
  always_comb begin
    if (ctl.mul_sel) begin
      mul_a = $signed(node.dir_x[31:16]);
      mul_b = $signed(wdy);
    end else begin
      mul_a = $signed(node.dir_y[31:16]);
      mul_b = $signed(wdx);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (ctl.keep_left) begin
      left_r <= prod_r[47:16];
    end
  end

endmodule

>>> design/bsp_point_locate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_point_locate_top
// Point location by walking a binary space partition node table.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel: a write transaction (in_cmd = 0) stores one node at
//   in_node_index in the same cycle it is accepted and gives no result.
//   A locate transaction (in_cmd = 1) walks from root_node towards a leaf and
//   returns one out_* transaction with the region index and overflow flag.
//   Config (cfg_*, APB style, pready tied high): 0x0 root_node, 0x4 node_count.
//   Write it only while the block is idle.
// Walk:
//   Each visited node is read in ST_CHECK and side-tested in ST_SIDE when a
//   vertical/horizontal line or the sign shortcut decides the side; when
//   the two 16.16 products have to be compared, ST_MUL_L, ST_MUL_R and ST_CMP
//   follow, since both go through the one shared 16x32 multiplier. A locate
//   passes ST_FINISH into the output register; an empty table skips the walk.
//   in_ready is low while a walk is running.
// Reset and stall:
//   rst_n clears the sequencer, step count, out_valid and config registers;
//   node table and data registers are not cleared. A finished result sits
//   in the output register and the block takes the next transaction; a
//   second result holds the sequencer, in_ready low, until out_ready frees it.
// ----------------------------------------------------------------------------
module bsp_point_locate_top #(
  parameter int MAX_NODES      = 4096,
  parameter int MAX_WALK_STEPS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [11:0] in_node_index,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_delta_x,
  input  logic [31:0] in_delta_y,
  input  logic [15:0] in_front_child,
  input  logic [15:0] in_back_child,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_region_index,
  output logic        out_walk_overflow,
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SW = $clog2(MAX_WALK_STEPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SIDE,
    ST_MUL_L,
    ST_MUL_R,
    ST_CMP,
    ST_FINISH
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] link_r, link_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [31:0] px_r, px_nxt;
  logic [31:0] py_r, py_nxt;
  logic [14:0] res_region_r, res_region_nxt;
  logic        res_ovf_r, res_ovf_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [14:0] out_region_r, out_region_nxt;
  logic        out_ovf_r, out_ovf_nxt;
  logic [15:0] root_node_r, root_node_nxt;
  logic [12:0] node_count_r, node_count_nxt;

  logic               in_fire;
  logic               cfg_wr;
  logic               wr_en;
  logic [15:0]        wr_idx;
  bpl_pkg::node_t     wr_node;
  logic               rd_en;
  bpl_pkg::node_t     rd_node;
  logic               link_bad;
  logic               steps_out;
  logic               load_out;
  bpl_pkg::mul_ctl_t  mul_ctl;
  bpl_pkg::side_sts_t side_sts;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_region_index  = out_region_r;
  assign out_walk_overflow = out_ovf_r;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[2])
      bpl_pkg::REG_ROOT:  cfg_prdata = {16'd0, root_node_r};
      bpl_pkg::REG_COUNT: cfg_prdata = {19'd0, node_count_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- node table ----------------
  assign wr_idx = {4'd0, in_node_index};
  assign wr_en  = in_fire && (in_cmd == bpl_pkg::CMD_WRITE) &&
                  ({16'd0, wr_idx} < 32'(MAX_NODES));

  assign wr_node.start_x = in_origin_x;
  assign wr_node.start_y = in_origin_y;
  assign wr_node.dir_x   = in_delta_x;
  assign wr_node.dir_y   = in_delta_y;
  assign wr_node.back    = in_back_child;
  assign wr_node.front   = in_front_child;

  // a non-leaf link is walkable only below both node_count and the table size
  assign link_bad  = ({16'd0, link_r} >= {19'd0, node_count_r}) ||
                     ({16'd0, link_r} >= 32'(MAX_NODES));
  assign steps_out = ({{(32-SW){1'b0}}, steps_r} >= 32'(MAX_WALK_STEPS));
  assign rd_en     = (state_r == ST_CHECK) && !link_r[bpl_pkg::LEAF_BIT] &&
                     !link_bad && !steps_out;

  bpl_node_mem #(
    .DEPTH (MAX_NODES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_node),
    .rd_en   (rd_en),
    .rd_addr (link_r[AW-1:0]),
    .rd_data (rd_node)
  );

  // ---------------- side test ----------------
  assign mul_ctl.mul_en    = (state_r == ST_MUL_L) || (state_r == ST_MUL_R);
  assign mul_ctl.mul_sel   = (state_r == ST_MUL_R);
  assign mul_ctl.keep_left = (state_r == ST_MUL_R);

  bpl_side_unit u_side (
    .clk     (clk),
    .node    (rd_node),
    .point_x (px_r),
    .point_y (py_r),
    .ctl     (mul_ctl),
    .sts     (side_sts)
  );

  // ---------------- sequencer ----------------
  assign load_out = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    link_nxt       = link_r;
    steps_nxt      = steps_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    res_region_nxt = res_region_r;
    res_ovf_nxt    = res_ovf_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_region_nxt = out_region_r;
    out_ovf_nxt    = out_ovf_r;
    root_node_nxt  = root_node_r;
    node_count_nxt = node_count_r;

    if (cfg_wr) begin
      if (cfg_paddr[2] == bpl_pkg::REG_ROOT) begin
        root_node_nxt = cfg_pwdata[15:0];
      end else begin
        node_count_nxt = cfg_pwdata[12:0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_cmd == bpl_pkg::CMD_LOCATE)) begin
          px_nxt         = in_point_x;
          py_nxt         = in_point_y;
          link_nxt       = root_node_r;
          steps_nxt      = '0;
          res_region_nxt = 15'd0;
          res_ovf_nxt    = 1'b0;
          state_nxt      = (node_count_r == 13'd0) ? ST_FINISH : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (link_r[bpl_pkg::LEAF_BIT]) begin
          res_region_nxt = link_r[14:0];
          state_nxt      = ST_FINISH;
        end else if (link_bad || steps_out) begin
          res_ovf_nxt = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          state_nxt = ST_SIDE;
        end
      end
      ST_SIDE: begin
        if (side_sts.resolved) begin
          link_nxt  = side_sts.side_fast ? rd_node.back : rd_node.front;
          steps_nxt = steps_r + 1'b1;
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_MUL_L;
        end
      end
      ST_MUL_L: state_nxt = ST_MUL_R;
      ST_MUL_R: state_nxt = ST_CMP;
      ST_CMP: begin
        link_nxt  = side_sts.side_mul ? rd_node.back : rd_node.front;
        steps_nxt = steps_r + 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_FINISH: begin
        if (load_out) begin
          out_valid_nxt  = 1'b1;
          out_region_nxt = res_region_r;
          out_ovf_nxt    = res_ovf_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      steps_r      <= '0;
      out_valid_r  <= 1'b0;
      root_node_r  <= 16'd0;
      node_count_r <= 13'd0;
    end else begin
      state_r      <= state_nxt;
      steps_r      <= steps_nxt;
      out_valid_r  <= out_valid_nxt;
      root_node_r  <= root_node_nxt;
      node_count_r <= node_count_nxt;
    end
    link_r       <= link_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    res_region_r <= res_region_nxt;
    res_ovf_r    <= res_ovf_nxt;
    out_region_r <= out_region_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  // ---------------- assertions ----------------
`include "bsp_point_locate_top_assert.svh"

  `BPL_ASSERT_NOW(a_steps_bound, 1'b1, steps_r <= SW'(MAX_WALK_STEPS))
  `BPL_ASSERT_NOW(a_read_in_range, rd_en, !link_r[bpl_pkg::LEAF_BIT] && !link_bad)
  `BPL_ASSERT_NOW(a_ovf_region_zero, load_out && res_ovf_r, res_region_r == 15'd0)
  `BPL_ASSERT_NEXT(a_busy_after_locate, in_fire && (in_cmd == bpl_pkg::CMD_LOCATE), !in_ready)

endmodule
